// File: src/circular_list_positional_delete_top_assert.svh
// Assertion macros for the circular list block.
`ifndef CIRCULAR_LIST_POSITIONAL_DELETE_TOP_ASSERT_SVH
`define CIRCULAR_LIST_POSITIONAL_DELETE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge out of reset.
`define CLPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("circular list assertion failed");
// Next-cycle implication, checked at every rising edge out of reset.
`define CLPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("circular list assertion failed");
`else
`define CLPD_ASSERT_NOW(label, ante, cons)
`define CLPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/clpd_pkg.sv
// Types and constants shared by the circular list block.
`timescale 1ns / 1ps
package clpd_pkg;

    localparam int KIND_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND    = 3'd0,
        KIND_DEL_FIRST = 3'd1,
        KIND_DEL_LAST  = 3'd2,
        KIND_DEL_POS   = 3'd3,
        KIND_DUMP      = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLINK,
        S_WALK,
        S_DUMP,
        S_EMIT
    } t_state;

endpackage

// File: src/circular_list_positional_delete_top.sv
// Top level of the circular doubly linked list with positional delete.
`timescale 1ns / 1ps
// Bounded list of signed 32-bit values, kept as a circular doubly linked
// list in three small RAMs (value, next link, prev link), each one entry per
// slot with one write port and a registered read. An append takes the lowest
// free slot; deletes remove the head, the tail or the entry at a 1-based
// position and return the removed value; a dump emits every value from head
// to tail with last set on the final one. Empty list, position zero or past
// the count, and full list come back as a status with item zero. Kinds 5 to 7
// are dropped with no result. Every result carries the entry count after the
// operation. One operation is in flight at a time: o_ready is high only while
// the sequencer is idle, but a finished result sits in the output register,
// so the next operation can be taken while it waits for i_ready. A rejected
// or empty-list operation and a first append go straight to the result; any
// other append first links the new tail; a delete reads its slot, walking
// the links from the head for a position; a dump emits one entry per cycle
// after the registered read of the head while the output is not stalled. The
// link walk reads one RAM entry per cycle. The RAMs need no clearing after
// reset: only linked slots are ever read.
module circular_list_positional_delete_top #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [clpd_pkg::KIND_W-1:0]          i_kind,
    input  logic signed [clpd_pkg::VALUE_W-1:0]  i_value,
    input  logic [clpd_pkg::POS_W-1:0]           i_position,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [clpd_pkg::STATUS_W-1:0]        o_status,
    output logic signed [clpd_pkg::VALUE_W-1:0]  o_item,
    output logic                                 o_last,
    output logic [clpd_pkg::LENGTH_W-1:0]        o_length
);
    import clpd_pkg::*;

    localparam int SW = $clog2(CAPACITY);       // slot index width
    localparam int CW = $clog2(CAPACITY + 1);   // entry count width

    // sequencer state
    t_state               r_state, n_state;
    logic [SW-1:0]        r_head, n_head;
    logic [SW-1:0]        r_tail, n_tail;
    logic [CW-1:0]        r_count, n_count;
    logic [CAPACITY-1:0]  r_free, n_free;
    logic [SW-1:0]        r_slot, n_slot;
    logic [POS_W-1:0]     r_idx, n_idx;
    logic [POS_W-1:0]     r_pos, n_pos;
    t_status              r_res_status, n_res_status;
    logic signed [VALUE_W-1:0] r_res_item, n_res_item;

    // output register
    logic                 r_out_valid;
    t_status              r_out_status;
    logic signed [VALUE_W-1:0] r_out_item;
    logic                 r_out_last;
    logic [LENGTH_W-1:0]  r_out_length;

    logic                 out_load;
    t_status              out_status;
    logic signed [VALUE_W-1:0] out_item;
    logic                 out_last;

    // RAM ports
    logic                 val_we, nxt_we, prv_we;
    logic [SW-1:0]        val_waddr, nxt_waddr, prv_waddr;
    logic [VALUE_W-1:0]   val_wdata;
    logic [SW-1:0]        nxt_wdata, prv_wdata;
    logic [VALUE_W-1:0]   val_rd;
    logic [SW-1:0]        nxt_rd, prv_rd;

    logic                 in_xfer;
    logic                 can_emit;
    logic                 list_empty;
    logic                 list_full;
    logic                 pos_bad;
    logic                 dump_last;
    logic                 walk_hit;
    logic [SW-1:0]        free_slot;

    assign o_ready    = (r_state == S_IDLE);
    assign in_xfer    = i_valid & o_ready;
    assign can_emit   = ~r_out_valid | i_ready;
    assign list_empty = (r_count == '0);
    assign list_full  = (r_count == CW'(CAPACITY));
    assign pos_bad    = (i_position == '0) || (i_position > POS_W'(r_count));
    assign dump_last  = (r_idx == POS_W'(r_count));
    assign walk_hit   = (r_idx == r_pos);

    // lowest free slot; only used when the list is not full
    always_comb begin
        free_slot = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (r_free[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    // read the slot the sequencer will look at next cycle
    clpd_ram #(.WIDTH(VALUE_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_raddr (n_slot),
        .o_rdata (val_rd)
    );

    clpd_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_waddr),
        .i_wdata (nxt_wdata),
        .i_raddr (n_slot),
        .o_rdata (nxt_rd)
    );

    clpd_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (prv_we),
        .i_waddr (prv_waddr),
        .i_wdata (prv_wdata),
        .i_raddr (n_slot),
        .o_rdata (prv_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_kind)
                        KIND_APPEND: begin
                            n_state = (list_full || list_empty) ? S_EMIT : S_APPLINK;
                        end
                        KIND_DEL_FIRST, KIND_DEL_LAST: begin
                            n_state = list_empty ? S_EMIT : S_WALK;
                        end
                        KIND_DEL_POS: begin
                            n_state = (list_empty || pos_bad) ? S_EMIT : S_WALK;
                        end
                        KIND_DUMP: begin
                            n_state = list_empty ? S_EMIT : S_DUMP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_APPLINK: n_state = S_EMIT;
            S_WALK:    n_state = walk_hit ? S_EMIT : S_WALK;
            S_DUMP:    n_state = (can_emit && dump_last) ? S_IDLE : S_DUMP;
            S_EMIT:    n_state = can_emit ? S_IDLE : S_EMIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // datapath, RAM writes and result outputs
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_free       = r_free;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_res_status = r_res_status;
        n_res_item   = r_res_item;
        val_we       = 1'b0;
        val_waddr    = free_slot;
        val_wdata    = i_value;
        nxt_we       = 1'b0;
        nxt_waddr    = free_slot;
        nxt_wdata    = free_slot;
        prv_we       = 1'b0;
        prv_waddr    = free_slot;
        prv_wdata    = free_slot;
        out_load     = 1'b0;
        out_status   = ST_OK;
        out_item     = '0;
        out_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_idx        = POS_W'(1);
                    n_pos        = POS_W'(1);
                    n_res_item   = '0;
                    n_res_status = ST_OK;
                    unique case (i_kind)
                        KIND_APPEND: begin
                            if (list_full) begin
                                n_res_status = ST_FULL;
                            end else begin
                                // write the new entry; its neighbors follow next cycle
                                val_we           = 1'b1;
                                nxt_we           = 1'b1;
                                prv_we           = 1'b1;
                                nxt_wdata        = list_empty ? free_slot : r_head;
                                prv_wdata        = list_empty ? free_slot : r_tail;
                                n_free[free_slot] = 1'b0;
                                n_count          = r_count + CW'(1);
                                n_slot           = free_slot;
                                if (list_empty) begin
                                    n_head = free_slot;
                                    n_tail = free_slot;
                                end
                            end
                        end
                        KIND_DEL_FIRST: begin
                            if (list_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_slot = r_head;
                            end
                        end
                        KIND_DEL_LAST: begin
                            if (list_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_slot = r_tail;
                            end
                        end
                        KIND_DEL_POS: begin
                            if (list_empty) begin
                                n_res_status = ST_EMPTY;
                            end else if (pos_bad) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_slot = r_head;
                                n_pos  = i_position;
                            end
                        end
                        KIND_DUMP: begin
                            if (list_empty) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_slot = r_head;
                            end
                        end
                        default: begin
                            n_res_status = ST_OK;
                        end
                    endcase
                end
            end
            S_APPLINK: begin
                // close the ring around the new tail
                nxt_we    = 1'b1;
                nxt_waddr = r_tail;
                nxt_wdata = r_slot;
                prv_we    = 1'b1;
                prv_waddr = r_head;
                prv_wdata = r_slot;
                n_tail    = r_slot;
            end
            S_WALK: begin
                if (walk_hit) begin
                    n_res_status   = ST_OK;
                    n_res_item     = val_rd;
                    n_free[r_slot] = 1'b1;
                    if (r_count <= CW'(1)) begin
                        n_count = '0;
                        n_head  = '0;
                        n_tail  = '0;
                    end else begin
                        nxt_we    = 1'b1;
                        nxt_waddr = prv_rd;
                        nxt_wdata = nxt_rd;
                        prv_we    = 1'b1;
                        prv_waddr = nxt_rd;
                        prv_wdata = prv_rd;
                        n_count   = r_count - CW'(1);
                        if (r_slot == r_head) begin
                            n_head = nxt_rd;
                        end
                        if (r_slot == r_tail) begin
                            n_tail = prv_rd;
                        end
                    end
                end else begin
                    n_slot = nxt_rd;
                    n_idx  = r_idx + POS_W'(1);
                end
            end
            S_DUMP: begin
                if (can_emit) begin
                    out_load   = 1'b1;
                    out_status = ST_OK;
                    out_item   = val_rd;
                    out_last   = dump_last;
                    if (!dump_last) begin
                        n_slot = nxt_rd;
                        n_idx  = r_idx + POS_W'(1);
                    end
                end
            end
            S_EMIT: begin
                if (can_emit) begin
                    out_load   = 1'b1;
                    out_status = r_res_status;
                    out_item   = r_res_item;
                    out_last   = 1'b1;
                end
            end
            default: begin
                n_slot = r_slot;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_slot      <= '0;
            r_idx       <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_free      <= n_free;
            r_slot      <= n_slot;
            r_idx       <= n_idx;
            r_pos       <= n_pos;
            r_out_valid <= out_load | (r_out_valid & ~i_ready);
        end
    end

    // held result and output payload; no reset needed
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_item   <= n_res_item;
        if (out_load) begin
            r_out_status <= out_status;
            r_out_item   <= out_item;
            r_out_last   <= out_last;
            r_out_length <= LENGTH_W'(r_count);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_item   = r_out_item;
    assign o_last   = r_out_last;
    assign o_length = r_out_length;

`include "circular_list_positional_delete_top_assert.svh"

    // every slot is either free or holds an entry
    `CLPD_ASSERT_NOW(a_free_matches_count, 1'b1, ($countones(r_free) + r_count) == CAPACITY)
    // an empty list keeps both end pointers at slot zero
    `CLPD_ASSERT_NOW(a_empty_ends, (r_count == '0) && (r_state == S_IDLE), (r_head == '0) && (r_tail == '0))
    // the position walk never runs past its target
    `CLPD_ASSERT_NOW(a_walk_bound, r_state == S_WALK, (r_idx <= r_pos) && (r_pos != '0))
    // a dump of a non-empty list enters the dump walk
    `CLPD_ASSERT_NEXT(a_dump_starts, in_xfer && (i_kind == KIND_DUMP) && (r_count != '0), r_state == S_DUMP)

endmodule

// File: src/clpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module clpd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read at the written address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
